FILE: design/nsfp_pkg.sv
// shared command and status types for the nearest square factor pair block
package nsfp_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a new number, arm the root counter
    logic sqrt_step;  // one root digit
    logic div_load;   // start a division with the next trial divisor
    logic div_first;  // trial divisor is the root itself (else divisor minus one)
    logic div_step;   // one quotient bit
    logic out_load;   // write the result register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic n_zero;     // captured number is zero
    logic cnt_last;   // step counter on its last iteration
    logic rem_zero;   // division remainder is zero
    logic d_le_one;   // trial divisor is one or less
  } sts_t;

endpackage

FILE: design/nearest_square_factor_pair.sv
// top level: nearest square factor pair of one unsigned number
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   in_tdata: number
//   out_     out  out_tvalid/out_tready out_tdata: small/large factor, out_tuser: invalid
//
// search: R = (W + 1) / 2 root digits, W = min(NUM_WIDTH, 16), then a W-bit division for each
//   of k trial divisors (1 up to 2^R - 1); a new number is taken only from idle
// zero input gives invalid with zero factors
// reset (rst_n low, synchronous) empties the result register and idles the controller
// a stalled output holds its result; the next number is taken meanwhile and
//   waits at the end of its search until the result register frees
module nearest_square_factor_pair #(
  parameter int NUM_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] number
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] small_factor, [23:8] large_factor
  output logic        out_tuser   // [0] invalid
);
  import nsfp_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [7:0]  small_factor;
  logic [15:0] large_factor;

  nsfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  nsfp_datapath #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_number        (in_tdata),
    .out_small_factor (small_factor),
    .out_large_factor (large_factor),
    .out_invalid      (out_tuser)
  );

  assign out_tdata = {large_factor, small_factor};

endmodule

FILE: design/nsfp_datapath.sv
// datapath: square root unit, restoring divider and result register
module nsfp_datapath #(
  parameter int NUM_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  nsfp_pkg::cmd_t cmd,
  output nsfp_pkg::sts_t sts,
  input  logic [15:0]   in_number,
  output logic [7:0]    out_small_factor,
  output logic [15:0]   out_large_factor,
  output logic          out_invalid
);
  import nsfp_pkg::*;

  localparam int NW = (NUM_WIDTH < 16) ? NUM_WIDTH : 16;
  localparam int RW = (NW + 1) / 2;
  localparam int PW = 2 * RW;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]   n_r;
  logic [PW-1:0]   sq_sh_r;
  logic [RW+1:0]   sq_rem_r;
  logic [RW-1:0]   root_r;
  logic [RW-1:0]   d_r;
  logic [NW-1:0]   q_r;
  logic [RW-1:0]   p_r;
  logic [CW-1:0]   cnt_r;
  logic [7:0]      small_r;
  logic [15:0]     large_r;
  logic            invalid_r;

  logic [RW+3:0]   rem_sh;
  logic [RW+3:0]   trial;
  logic [RW+3:0]   rem_diff;
  logic [RW:0]     div_t;
  logic [RW:0]     div_diff;

  // root digit: bring down two bits, try (root * 4 + 1)
  assign rem_sh   = {sq_rem_r, sq_sh_r[PW-1:PW-2]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign rem_diff = rem_sh - trial;

  // quotient bit: shift in the next dividend bit, try the divisor
  assign div_t    = {p_r, q_r[NW-1]};
  assign div_diff = div_t - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r      <= in_number[NW-1:0];
      sq_sh_r  <= PW'(in_number[NW-1:0]);
      sq_rem_r <= '0;
      root_r   <= '0;
      cnt_r    <= CW'(RW);
    end
    if (cmd.sqrt_step) begin
      sq_sh_r <= {sq_sh_r[PW-3:0], 2'b00};
      cnt_r   <= cnt_r - 1'b1;
      if (rem_sh >= trial) begin
        sq_rem_r <= rem_diff[RW+1:0];
        root_r   <= {root_r[RW-2:0], 1'b1};
      end else begin
        sq_rem_r <= rem_sh[RW+1:0];
        root_r   <= {root_r[RW-2:0], 1'b0};
      end
    end
    if (cmd.div_load) begin
      d_r   <= cmd.div_first ? root_r : d_r - 1'b1;
      q_r   <= n_r;
      p_r   <= '0;
      cnt_r <= CW'(NW);
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r - 1'b1;
      if (div_t >= {1'b0, d_r}) begin
        p_r <= div_diff[RW-1:0];
        q_r <= {q_r[NW-2:0], 1'b1};
      end else begin
        p_r <= div_t[RW-1:0];
        q_r <= {q_r[NW-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      invalid_r <= sts.n_zero;
      small_r   <= sts.n_zero ? 8'd0 : 8'(d_r);
      large_r   <= sts.n_zero ? 16'd0 : 16'(q_r);
    end
  end

  assign sts.n_zero   = (n_r == '0);
  assign sts.cnt_last = (cnt_r == CW'(1));
  assign sts.rem_zero = (p_r == '0);
  assign sts.d_le_one = (d_r <= RW'(1));

  assign out_small_factor = small_r;
  assign out_large_factor = large_r;
  assign out_invalid      = invalid_r;

  // partial remainder stays below the divisor through a division
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (p_r < d_r))
    else $error("partial remainder not below divisor");

  // first trial divisor is the floor square root
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_load && cmd.div_first) |->
      (32'(root_r) * 32'(root_r) <= 32'(n_r)) &&
      ((32'(root_r) + 32'd1) * (32'(root_r) + 32'd1) > 32'(n_r)))
    else $error("square root out of range");

  // a nonzero number ends on an exact nonzero divisor
  a_exact_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !sts.n_zero) |-> (sts.rem_zero && d_r != '0))
    else $error("result divisor is not exact");

endmodule

FILE: design/nsfp_ctrl.sv
// controller: sequences root, trial divisions and result handoff
module nsfp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output nsfp_pkg::cmd_t cmd,
  input  nsfp_pkg::sts_t sts
);
  import nsfp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SQRT   = 6'b000010,
    S_START  = 6'b000100,
    S_DIV    = 6'b001000,
    S_CHECK  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts.n_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.sqrt_step = 1'b1;
          if (sts.cnt_last) state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.div_load  = 1'b1;
        cmd.div_first = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_last) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.rem_zero || sts.d_le_one) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.div_load = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // a result is never written over one that waits untaken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.out_load)
    else $error("result register overwritten");

endmodule
